// File: rtl/paqi_pkg.sv
package paqi_pkg;

   localparam int unsigned ConcW    = 16;
   localparam int unsigned KindW    = 2;
   localparam int unsigned AqiW     = 9;
   localparam int unsigned C10W     = 13;  // concentration in tenths, 0..6040
   localparam int unsigned DiffW    = 12;  // offset into a segment, 0..2499
   localparam int unsigned DihW     = 8;   // index span of a segment, 0..199
   localparam int unsigned NumW     = 20;  // 2*num + den < 2^20
   localparam int unsigned RcpW     = 26;
   localparam int unsigned RcpShift = 33;  // exact floor division for n < 2^20, d < 2^13
   localparam int unsigned ProdW    = NumW + RcpW;
   localparam int unsigned QW       = 8;   // quotient never exceeds the index span
   localparam int unsigned SegIdxW  = 3;
   localparam int unsigned NumSeg   = 8;

   localparam logic [KindW-1:0] KindPm1  = 2'd0;
   localparam logic [KindW-1:0] KindPm25 = 2'd1;
   localparam logic [KindW-1:0] KindPm10 = 2'd2;

   localparam logic [ConcW-1:0] MaxConc = 16'd604;

   typedef struct packed {
      logic [C10W-1:0]  lo;
      logic [C10W-1:0]  hi;
      logic [AqiW-1:0]  ilo;
      logic [DihW-1:0]  dih;
      logic [DiffW-1:0] den;
      logic [RcpW-1:0]  rcp;  // ceil(2^RcpShift / (2*den))
   } seg_const_type;

   typedef struct packed {
      logic                ok;
      logic                pm10;
      logic [SegIdxW-1:0]  idx;
   } seg_ctl_type;

   // unused slots never match: lo above hi
   localparam seg_const_type SegPad = '{13'h1FFF, 13'd0, 9'd0, 8'd0, 12'd1, 26'd0};

   localparam seg_const_type Pm25Tab [NumSeg] = '{
      '{13'd0,    13'd120,  9'd0,   8'd50,  12'd120,
        26'(((64'd1 << RcpShift) + 64'd239)  / 64'd240)},
      '{13'd121,  13'd354,  9'd51,  8'd49,  12'd233,
        26'(((64'd1 << RcpShift) + 64'd465)  / 64'd466)},
      '{13'd355,  13'd554,  9'd101, 8'd49,  12'd199,
        26'(((64'd1 << RcpShift) + 64'd397)  / 64'd398)},
      '{13'd555,  13'd1504, 9'd151, 8'd49,  12'd949,
        26'(((64'd1 << RcpShift) + 64'd1897) / 64'd1898)},
      '{13'd1505, 13'd2504, 9'd201, 8'd99,  12'd999,
        26'(((64'd1 << RcpShift) + 64'd1997) / 64'd1998)},
      '{13'd2505, 13'd5004, 9'd301, 8'd199, 12'd2499,
        26'(((64'd1 << RcpShift) + 64'd4997) / 64'd4998)},
      SegPad,
      SegPad
   };

   localparam seg_const_type Pm10Tab [NumSeg] = '{
      '{13'd0,    13'd540,  9'd0,   8'd50, 12'd540,
        26'(((64'd1 << RcpShift) + 64'd1079) / 64'd1080)},
      '{13'd550,  13'd1540, 9'd51,  8'd49, 12'd990,
        26'(((64'd1 << RcpShift) + 64'd1979) / 64'd1980)},
      '{13'd1550, 13'd2540, 9'd101, 8'd49, 12'd990,
        26'(((64'd1 << RcpShift) + 64'd1979) / 64'd1980)},
      '{13'd2550, 13'd3540, 9'd151, 8'd49, 12'd990,
        26'(((64'd1 << RcpShift) + 64'd1979) / 64'd1980)},
      '{13'd3550, 13'd4240, 9'd201, 8'd99, 12'd690,
        26'(((64'd1 << RcpShift) + 64'd1379) / 64'd1380)},
      '{13'd4250, 13'd5040, 9'd301, 8'd99, 12'd790,
        26'(((64'd1 << RcpShift) + 64'd1579) / 64'd1580)},
      '{13'd5050, 13'd6040, 9'd401, 8'd99, 12'd990,
        26'(((64'd1 << RcpShift) + 64'd1979) / 64'd1980)},
      SegPad
   };

   function automatic seg_const_type seg_get(input logic pm10,
                                             input logic [SegIdxW-1:0] idx);
      return pm10 ? Pm10Tab[idx] : Pm25Tab[idx];
   endfunction

endpackage

// File: rtl/particulate_aqi_interpolator_top.sv
// Particulate AQI interpolator.
// Input: drive req_concentration (ug/m3) and req_kind (0 PM1.0, 1 PM2.5,
// 2 PM10, 3 invalid) with start high; the transfer happens at the rising
// edge where start is high and busy is low. busy is always low, so a new
// item can be offered every cycle.
// Output: rsp_valid pulses for one cycle per item, in input order, with
// rsp_aqi (0..500) and rsp_valid_res. rsp_valid_res is 0 (and rsp_aqi 0)
// for an invalid kind or a concentration outside every breakpoint segment.
// Each accepted item passes through six register stages in order (scale,
// segment select, multiply, add, reciprocal multiply, output); rsp_valid is
// the valid bit of the output stage. Throughput: one item per cycle.
// The receiver cannot stall; a result is seen for exactly one cycle.
// Reset (synchronous, active high) clears every in-flight item; no result
// strobes until new items arrive. No clearing pass is needed.
module particulate_aqi_interpolator_top
   import paqi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ConcW-1:0]   req_concentration,
   input  logic [KindW-1:0]   req_kind,
   output logic               rsp_valid,
   output logic [AqiW-1:0]    rsp_aqi,
   output logic               rsp_valid_res
);

   logic             req_take;
   logic             seg_vld;
   seg_ctl_type      seg_ctl;
   logic [DiffW-1:0] seg_diff;

   // fully pipelined, never blocks the sender
   assign busy     = 1'b0;
   assign req_take = start && !busy;

   // range check, scaling by ten, parallel segment compares
   paqi_seg u_seg (
      .clock             (clock),
      .reset             (reset),
      .req_take          (req_take),
      .req_concentration (req_concentration),
      .req_kind          (req_kind),
      .seg_vld           (seg_vld),
      .seg_ctl           (seg_ctl),
      .seg_diff          (seg_diff)
   );

   // interpolation and rounded constant-divisor division
   paqi_interp u_interp (
      .clock         (clock),
      .reset         (reset),
      .seg_vld       (seg_vld),
      .seg_ctl       (seg_ctl),
      .seg_diff      (seg_diff),
      .rsp_valid     (rsp_valid),
      .rsp_aqi       (rsp_aqi),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

// File: rtl/paqi_seg.sv
module paqi_seg
   import paqi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_take,
   input  logic [ConcW-1:0]   req_concentration,
   input  logic [KindW-1:0]   req_kind,
   output logic               seg_vld,
   output seg_ctl_type        seg_ctl,
   output logic [DiffW-1:0]   seg_diff
);

   // stage 1: range check and scale by ten
   logic              v1_ff, v1_in;
   logic              ok1_ff, ok1_in;
   logic              pm10_1_ff, pm10_1_in;
   logic [C10W-1:0]   c10_1_ff, c10_1_in;

   // stage 2: segment select
   logic              v2_ff, v2_in;
   seg_ctl_type       ctl2_ff, ctl2_in;
   logic [DiffW-1:0]  diff2_ff, diff2_in;

   logic [NumSeg-1:0]  hit;
   logic [SegIdxW-1:0] pick;
   seg_const_type      sel;
   logic [13:0]        c_ext;

   always_comb begin
      c_ext     = {4'd0, req_concentration[9:0]};
      v1_in     = req_take;
      ok1_in    = (req_kind == KindPm1 || req_kind == KindPm25 || req_kind == KindPm10)
                  && (req_concentration <= MaxConc);
      pm10_1_in = (req_kind == KindPm10);
      c10_1_in  = C10W'((c_ext << 3) + (c_ext << 1));
   end

   always_comb begin
      for (int i = 0; i < NumSeg; i++) begin
         hit[i] = (c10_1_ff >= seg_get(pm10_1_ff, SegIdxW'(i)).lo)
               && (c10_1_ff <= seg_get(pm10_1_ff, SegIdxW'(i)).hi);
      end
      // first matching segment wins
      pick = '0;
      for (int i = NumSeg - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pick = SegIdxW'(i);
         end
      end
      sel          = seg_get(pm10_1_ff, pick);
      v2_in        = v1_ff;
      ctl2_in.ok   = ok1_ff && (|hit);
      ctl2_in.pm10 = pm10_1_ff;
      ctl2_in.idx  = pick;
      diff2_in     = DiffW'(c10_1_ff - sel.lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff    <= ok1_in;
      pm10_1_ff <= pm10_1_in;
      c10_1_ff  <= c10_1_in;
      ctl2_ff   <= ctl2_in;
      diff2_ff  <= diff2_in;
   end

   assign seg_vld  = v2_ff;
   assign seg_ctl  = ctl2_ff;
   assign seg_diff = diff2_ff;

endmodule

// File: rtl/paqi_interp.sv
module paqi_interp
   import paqi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               seg_vld,
   input  seg_ctl_type        seg_ctl,
   input  logic [DiffW-1:0]   seg_diff,
   output logic               rsp_valid,
   output logic [AqiW-1:0]    rsp_aqi,
   output logic               rsp_valid_res
);

   // stage 3: span * offset
   logic              v3_ff, v3_in;
   seg_ctl_type       ctl3_ff;
   logic [NumW-1:0]   num3_ff, num3_in;
   // stage 4: 2*num + den
   logic              v4_ff, v4_in;
   seg_ctl_type       ctl4_ff;
   logic [NumW-1:0]   n2_4_ff, n2_4_in;
   // stage 5: reciprocal multiply
   logic              v5_ff, v5_in;
   seg_ctl_type       ctl5_ff;
   logic [QW-1:0]     q5_ff, q5_in;
   // stage 6: result register
   logic              out_v_ff, out_v_in;
   logic [AqiW-1:0]   aqi_ff, aqi_in;
   logic              vres_ff, vres_in;

   seg_const_type     t3, t4, t5, t6;
   logic [ProdW-1:0]  prod;

   always_comb begin
      t3      = seg_get(seg_ctl.pm10, seg_ctl.idx);
      t4      = seg_get(ctl3_ff.pm10, ctl3_ff.idx);
      t5      = seg_get(ctl4_ff.pm10, ctl4_ff.idx);
      t6      = seg_get(ctl5_ff.pm10, ctl5_ff.idx);

      v3_in   = seg_vld;
      num3_in = NumW'(t3.dih) * NumW'(seg_diff);

      v4_in   = v3_ff;
      n2_4_in = NumW'({num3_ff, 1'b0}) + NumW'(t4.den);

      // floor(n2 / (2*den)) gives half-up rounding of num/den
      v5_in   = v4_ff;
      prod    = ProdW'(n2_4_ff) * ProdW'(t5.rcp);
      q5_in   = prod[RcpShift +: QW];

      out_v_in = v5_ff;
      vres_in  = ctl5_ff.ok;
      aqi_in   = ctl5_ff.ok ? AqiW'(t6.ilo + AqiW'(q5_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         v5_ff    <= v5_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl3_ff <= seg_ctl;
      num3_ff <= num3_in;
      ctl4_ff <= ctl3_ff;
      n2_4_ff <= n2_4_in;
      ctl5_ff <= ctl4_ff;
      q5_ff   <= q5_in;
      aqi_ff  <= aqi_in;
      vres_ff <= vres_in;
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_aqi       = aqi_ff;
   assign rsp_valid_res = vres_ff;

   a_q_in_span: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && ctl5_ff.ok) |-> (q5_ff <= t6.dih))
      else $error("quotient exceeds segment span");

   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      v5_ff |=> out_v_ff)
      else $error("result lost between last stage and output");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !vres_ff) |-> (aqi_ff == '0))
      else $error("invalid result carries nonzero index");

   a_aqi_range: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && vres_ff) |-> (aqi_ff <= AqiW'(500)))
      else $error("index above 500");

endmodule
